FILE: rtl/wfps_pkg.sv
// Shared types, constants and formats for the wall-follow PID steering block.
package wfps_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 16;

   // datapath widths
   localparam int RANGE_W  = 15;
   localparam int XY_W     = 36;   // CORDIC vector, Q16 mm
   localparam int CS_W     = 34;   // cos/sin, Q30
   localparam int ACC_W    = 52;   // projection accumulator
   localparam int ERR_W    = 17;
   localparam int LERR_W   = 18;
   localparam int SUM_W    = 40;
   localparam int PID_W    = 60;
   localparam int DIV_SH   = 11;   // 256000 = 125 << 11
   localparam int QN_W     = 22;   // |S| >> 11 below saturation
   localparam int Q_W      = 15;   // quotient bits below saturation
   localparam int RECIP_W  = 23;
   localparam int RECIP_SH = 29;
   localparam int STEER_W  = 16;
   localparam int SPEED_W  = 11;

   localparam logic [15:0] COS70_Q16 = 16'd22415;
   localparam logic [15:0] SIN70_Q16 = 16'd61584;
   localparam logic signed [CS_W-1:0] INV_GAIN_Q30 = 34'sd652032875;
   localparam logic signed [CS_W-1:0] ONE_Q30      = 34'sd1073741824;
   localparam logic signed [ACC_W-1:0] HALF_Q30    = 52'sd536870912;
   // ceil(2^29 / 125); exact floor for every dividend below 2^22
   localparam logic [RECIP_W-1:0] RECIP_125 = 23'd4294968;
   // 32768 * 256000: at or above this the quotient saturates
   localparam logic [PID_W-1:0] SAT_LIMIT = 60'd8388608000;
   localparam logic signed [ERR_W+5:0] ERR_MAX = 23'sd65535;
   localparam logic signed [ERR_W+5:0] ERR_MIN = -23'sd65536;
   localparam logic signed [SUM_W:0] SUM_MAX = 41'sd549755813887;
   localparam logic signed [SUM_W:0] SUM_MIN = -41'sd549755813888;

   localparam logic [SPEED_W-1:0] SPEED_FAST = 11'd1500;
   localparam logic [SPEED_W-1:0] SPEED_MED  = 11'd1000;
   localparam logic [SPEED_W-1:0] SPEED_SLOW = 11'd500;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH = 3'd6;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [14:0] target;
      logic [13:0] lookahead;
      logic [14:0] band_low;
      logic [14:0] band_high;
   } cfg_type;

   typedef enum logic [3:0] {
      STEP_NONE, STEP_LOAD, STEP_CORDIC, STEP_PROJ_BC, STEP_PROJ_LS, STEP_ERR,
      STEP_PID_P, STEP_PID_ILO, STEP_PID_IHI, STEP_PID_D, STEP_ABS, STEP_DIV,
      STEP_OUT
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CORDIC, ST_PROJ_BC, ST_PROJ_LS, ST_ERR, ST_PID_P, ST_PID_ILO,
      ST_PID_IHI, ST_PID_D, ST_ABS, ST_DIV, ST_FIN
   } state_type;

   typedef struct packed {
      step_type step;
   } cmd_type;

endpackage

FILE: rtl/wfps_if.sv
// Valid/ready channel interfaces for request and response words.
interface wfps_req_if;
   logic        valid;
   logic        ready;
   logic [14:0] range_a_mm;
   logic [14:0] range_b_mm;
   modport source (output valid, range_a_mm, range_b_mm, input ready);
   modport sink   (input valid, range_a_mm, range_b_mm, output ready);
endinterface

interface wfps_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] steering_value;
   logic [10:0]        speed_mm_s;
   logic signed [16:0] distance_error_mm;
   modport source (output valid, steering_value, speed_mm_s, distance_error_mm, input ready);
   modport sink   (input valid, steering_value, speed_mm_s, distance_error_mm, output ready);
endinterface

FILE: rtl/wfps_ctrl.sv
// Sequencer: steps the datapath through CORDIC, projection, PID and divide.
module wfps_ctrl #(
   parameter int CORDIC_ITERATIONS = wfps_pkg::CORDIC_ITERATIONS_DEF,
   parameter int CNT_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wfps_pkg::cmd_type cmd,
   output logic [CNT_W-1:0]  iter
);
   import wfps_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.step     = STEP_NONE;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = STEP_LOAD;
               cnt_in   = '0;
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            cmd.step = STEP_CORDIC;
            if (cnt_ff == CNT_W'(CORDIC_ITERATIONS - 1)) begin
               cnt_in   = '0;
               state_in = ST_PROJ_BC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PROJ_BC: begin
            cmd.step = STEP_PROJ_BC;
            state_in = ST_PROJ_LS;
         end
         ST_PROJ_LS: begin
            cmd.step = STEP_PROJ_LS;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.step = STEP_ERR;
            state_in = ST_PID_P;
         end
         ST_PID_P: begin
            cmd.step = STEP_PID_P;
            state_in = ST_PID_ILO;
         end
         ST_PID_ILO: begin
            cmd.step = STEP_PID_ILO;
            state_in = ST_PID_IHI;
         end
         ST_PID_IHI: begin
            cmd.step = STEP_PID_IHI;
            state_in = ST_PID_D;
         end
         ST_PID_D: begin
            cmd.step = STEP_PID_D;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.step = STEP_ABS;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = STEP_DIV;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.step     = STEP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign iter      = cnt_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/wfps_datapath.sv
// Datapath: CORDIC vectoring, wall projection, PID accumulate, divide, output regs.
module wfps_datapath #(
   parameter int CNT_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wfps_pkg::cmd_type           cmd,
   input  logic [CNT_W-1:0]            iter,
   input  wfps_pkg::cfg_type           cfg,
   input  logic [14:0]                 req_range_a_mm,
   input  logic [14:0]                 req_range_b_mm,
   output logic signed [15:0]          rsp_steering_value,
   output logic [10:0]                 rsp_speed_mm_s,
   output logic signed [16:0]          rsp_distance_error_mm
);
   import wfps_pkg::*;

   logic [RANGE_W-1:0]      b_ff, b_in;
   logic                    zero_a_ff, zero_a_in;
   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [CS_W-1:0]  c_ff, c_in, s_ff, s_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [LERR_W-1:0] last_err_ff, last_err_in;
   logic signed [SUM_W-1:0] esum_ff, esum_in;
   logic signed [PID_W-1:0] pacc_ff, pacc_in;
   logic                    neg_ff, neg_in, sat_ff, sat_in;
   logic [QN_W-1:0]         n_ff, n_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic signed [STEER_W-1:0] steer_ff, steer_in;
   logic [SPEED_W-1:0]      speed_ff, speed_in;
   logic signed [ERR_W-1:0] derr_ff, derr_in;

   // scratch
   logic [30:0]             ax_p, ay_p;
   logic signed [XY_W-1:0]  xs, ys;
   logic signed [CS_W-1:0]  cs, ss;
   logic signed [49:0]      prod_bc;
   logic signed [48:0]      prod_ls;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-31:0] proj;
   logic signed [ERR_W+5:0] diff;
   logic signed [SUM_W:0]   sum_ext;
   logic signed [33:0]      prod_p;
   logic signed [37:0]      prod_ilo;
   logic signed [36:0]      prod_ihi;
   logic signed [18:0]      dd;
   logic signed [35:0]      prod_d;
   logic [PID_W-1:0]        mag;
   logic [QN_W+RECIP_W-1:0] qprod;
   logic signed [STEER_W-1:0] qs;
   logic [STEER_W:0]        smag;

   always_ff @(posedge clock) begin
      if (reset) begin
         esum_ff     <= '0;
         last_err_ff <= '0;
      end else begin
         esum_ff     <= esum_in;
         last_err_ff <= last_err_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff      <= b_in;
      zero_a_ff <= zero_a_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      c_ff      <= c_in;
      s_ff      <= s_in;
      acc_ff    <= acc_in;
      err_ff    <= err_in;
      pacc_ff   <= pacc_in;
      neg_ff    <= neg_in;
      sat_ff    <= sat_in;
      n_ff      <= n_in;
      q_ff      <= q_in;
      steer_ff  <= steer_in;
      speed_ff  <= speed_in;
      derr_ff   <= derr_in;
   end

   always_comb begin
      b_in = b_ff;  zero_a_in = zero_a_ff;
      x_in = x_ff;  y_in = y_ff;  c_in = c_ff;  s_in = s_ff;
      acc_in = acc_ff;  err_in = err_ff;  last_err_in = last_err_ff;
      esum_in = esum_ff;  pacc_in = pacc_ff;  neg_in = neg_ff;  sat_in = sat_ff;
      n_in = n_ff;  q_in = q_ff;
      steer_in = steer_ff;  speed_in = speed_ff;  derr_in = derr_ff;

      ax_p  = req_range_a_mm * SIN70_Q16;
      ay_p  = req_range_a_mm * COS70_Q16;
      xs    = x_ff >>> iter;
      ys    = y_ff >>> iter;
      cs    = c_ff >>> iter;
      ss    = s_ff >>> iter;
      prod_bc  = $signed({1'b0, b_ff}) * c_ff;
      prod_ls  = $signed({1'b0, cfg.lookahead}) * s_ff;
      rnd      = acc_ff + HALF_Q30;
      proj     = rnd[ACC_W-1:30];
      diff     = (ERR_W+6)'($signed({1'b0, cfg.target})) - (ERR_W+6)'(proj);
      sum_ext  = (SUM_W+1)'(esum_ff) + (SUM_W+1)'(err_ff);
      prod_p   = $signed({1'b0, cfg.gain_p}) * err_ff;
      prod_ilo = $signed({1'b0, cfg.gain_i}) * $signed({1'b0, esum_ff[19:0]});
      prod_ihi = $signed({1'b0, cfg.gain_i}) * $signed(esum_ff[SUM_W-1:20]);
      dd       = 19'(err_ff) - 19'(last_err_ff);
      prod_d   = $signed({1'b0, cfg.gain_d}) * dd;
      mag      = pacc_ff[PID_W-1] ? PID_W'(-pacc_ff) : PID_W'(pacc_ff);
      // |S| / 256000 = (|S| >> 11) / 125, by reciprocal multiply
      qprod    = n_ff * RECIP_125;
      qs       = $signed({1'b0, q_ff});
      smag     = {2'b00, q_ff};

      case (cmd.step)
         STEP_LOAD: begin
            b_in      = req_range_b_mm;
            zero_a_in = (req_range_a_mm == '0);
            x_in      = $signed({{(XY_W-31){1'b0}}, ax_p});
            y_in      = $signed({{(XY_W-31){1'b0}}, req_range_b_mm, 16'b0})
                      - $signed({{(XY_W-31){1'b0}}, ay_p});
            c_in      = (req_range_a_mm == '0) ? ONE_Q30 : INV_GAIN_Q30;
            s_in      = '0;
         end
         STEP_CORDIC: begin
            // rotate toward the x axis; the unit vector turns the opposite way
            if (!zero_a_ff) begin
               if (!y_ff[XY_W-1]) begin
                  x_in = x_ff + ys;  y_in = y_ff - xs;
                  c_in = c_ff - ss;  s_in = s_ff + cs;
               end else begin
                  x_in = x_ff - ys;  y_in = y_ff + xs;
                  c_in = c_ff + ss;  s_in = s_ff - cs;
               end
            end
         end
         STEP_PROJ_BC: acc_in = ACC_W'(prod_bc);
         STEP_PROJ_LS: acc_in = acc_ff + ACC_W'(prod_ls);
         STEP_ERR: begin
            if (diff > ERR_MAX)      err_in = ERR_W'(ERR_MAX);
            else if (diff < ERR_MIN) err_in = ERR_W'(ERR_MIN);
            else                     err_in = ERR_W'(diff);
         end
         STEP_PID_P: begin
            if (sum_ext > SUM_MAX)      esum_in = SUM_W'(SUM_MAX);
            else if (sum_ext < SUM_MIN) esum_in = SUM_W'(SUM_MIN);
            else                        esum_in = SUM_W'(sum_ext);
            pacc_in = PID_W'(prod_p);
         end
         STEP_PID_ILO: pacc_in = pacc_ff + PID_W'(prod_ilo);
         STEP_PID_IHI: pacc_in = pacc_ff + (PID_W'(prod_ihi) <<< 20);
         STEP_PID_D: begin
            pacc_in     = pacc_ff + PID_W'(prod_d);
            last_err_in = LERR_W'(err_ff);
         end
         STEP_ABS: begin
            neg_in = pacc_ff[PID_W-1];
            sat_in = (mag >= SAT_LIMIT);
            n_in   = mag[QN_W+DIV_SH-1:DIV_SH];
         end
         STEP_DIV: q_in = qprod[RECIP_SH+Q_W-1:RECIP_SH];
         STEP_OUT: begin
            // steering = -trunc(S / 256000), saturated
            if (sat_ff) begin
               steer_in = neg_ff ? 16'sd32767 : -16'sd32768;
               smag     = neg_ff ? 17'd32767 : 17'd32768;
            end else begin
               steer_in = neg_ff ? qs : -qs;
            end
            if (smag <= {2'b00, cfg.band_low})       speed_in = SPEED_FAST;
            else if (smag <= {2'b00, cfg.band_high}) speed_in = SPEED_MED;
            else                                     speed_in = SPEED_SLOW;
            derr_in = err_ff;
         end
         default: ;
      endcase
   end

   assign rsp_steering_value    = steer_ff;
   assign rsp_speed_mm_s        = speed_ff;
   assign rsp_distance_error_mm = derr_ff;

endmodule

FILE: rtl/wall_follow_pid_steering_top.sv
// Top level: config registers, sequencer and datapath of the wall-follow steering block.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+---------------------------------------------
//   req_ch  | in  | valid/ready        | range_a_mm[14:0], range_b_mm[14:0]
//   rsp_ch  | out | valid/ready        | steering_value[15:0] s, speed_mm_s[10:0],
//           |     |                    | distance_error_mm[16:0] s
//   csr_*   | in  | wr_en only         | index[2:0], wdata[15:0], no read-back
//
// A word passes from accept to response valid through the CORDIC micro-rotations,
// the two projection multiplies, the error and PID steps, the magnitude, the
// reciprocal multiply that divides by 256000, and the output load.
// req_ch.ready is high only while the sequencer is idle, so a new request is not
// taken before the sequencer is done with the last one; a finished response sits
// in the output register, so the next request is taken while it waits.
// If the previous response is still unread when the next one is done, the
// sequencer holds in its final step until rsp_ch.ready.
// Synchronous active-high reset clears the registers to defaults, the error
// sum and the previous error; there is no clearing pass.
module wall_follow_pid_steering_top #(
   parameter int CORDIC_ITERATIONS = wfps_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   wfps_req_if.sink                        req_ch,
   wfps_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [wfps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wfps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wfps_pkg::*;

   // counter covers the rotation count
   localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

   cfg_type          cfg_ff, cfg_in;
   cmd_type          cmd;
   logic [CNT_W-1:0] iter;

   // register file; writes must come only while idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p    <= 16'd7680;
         cfg_ff.gain_i    <= 16'd0;
         cfg_ff.gain_d    <= 16'd77;
         cfg_ff.target    <= 15'd825;
         cfg_ff.lookahead <= 14'd100;
         cfg_ff.band_low  <= 15'd10;
         cfg_ff.band_high <= 15'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_P:    cfg_in.gain_p    = csr_wdata;
            CSR_GAIN_I:    cfg_in.gain_i    = csr_wdata;
            CSR_GAIN_D:    cfg_in.gain_d    = csr_wdata;
            CSR_TARGET:    cfg_in.target    = csr_wdata[14:0];
            CSR_LOOKAHEAD: cfg_in.lookahead = csr_wdata[13:0];
            CSR_BAND_LOW:  cfg_in.band_low  = csr_wdata[14:0];
            CSR_BAND_HIGH: cfg_in.band_high = csr_wdata[14:0];
            default: ;     // unmapped index: ignored
         endcase
      end
   end

   wfps_ctrl #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
      .CNT_W             (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .iter      (iter)
   );

   wfps_datapath #(
      .CNT_W (CNT_W)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .iter                  (iter),
      .cfg                   (cfg_ff),
      .req_range_a_mm        (req_ch.range_a_mm),
      .req_range_b_mm        (req_ch.range_b_mm),
      .rsp_steering_value    (rsp_ch.steering_value),
      .rsp_speed_mm_s        (rsp_ch.speed_mm_s),
      .rsp_distance_error_mm (rsp_ch.distance_error_mm)
   );

endmodule

FILE: rtl/wfps_checker.sv
// Port-level assertions for the wall-follow steering block, bound to the top level.
module wfps_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] steering_value,
   input logic [10:0]        speed_mm_s,
   input logic signed [16:0] distance_error_mm
);
   import wfps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(steering_value)
         && $stable(speed_mm_s) && $stable(distance_error_mm))
      else $error("response word changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in flight");

   a_speed_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> speed_mm_s == SPEED_FAST || speed_mm_s == SPEED_MED
         || speed_mm_s == SPEED_SLOW)
      else $error("speed outside the three bands");

   a_sat_slow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && steering_value == -16'sd32768 |-> speed_mm_s == SPEED_SLOW)
      else $error("full negative steering without slow speed");

endmodule

bind wall_follow_pid_steering_top wfps_checker u_wfps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .steering_value    (rsp_ch.steering_value),
   .speed_mm_s        (rsp_ch.speed_mm_s),
   .distance_error_mm (rsp_ch.distance_error_mm)
);
